### src/odo_pkg.sv
`default_nettype none
package odo_pkg;

	localparam int NUM_CHANNELS_DEF = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MAX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEILING  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT  = 3'd5;

	localparam logic [23:0] DIST_PER_PULSE_RESET = 24'd65536;
	localparam logic [19:0] PERIOD_MIN_RESET     = 20'd1000;
	localparam logic [19:0] PERIOD_MAX_RESET     = 20'd1000000;
	localparam logic [23:0] SPEED_CEILING_RESET  = 24'd10000000;
	localparam logic [15:0] SPEED_LIMIT_RESET    = 16'd51200;
	localparam logic [15:0] STALL_TIMEOUT_RESET  = 16'd200;

	localparam logic [19:0] PERIOD_RESET = 20'd100000;

	localparam logic [26:0] US_PER_MS      = 27'd1000;
	localparam logic [26:0] US_PER_MS_LESS = 27'd999;
	localparam logic [43:0] US_PER_S       = 44'd1000000;

	// quotient bits kept by the divider, one above the speed width
	localparam int QUO_W  = 17;
	localparam int NUM_W  = 36;
	localparam int STEP_W = 5;

	typedef struct packed {
		logic [23:0] pulse_length;
		logic [19:0] period_min_us;
		logic [19:0] period_max_us;
		logic [23:0] speed_period_ceiling_us;
		logic [15:0] speed_limit;
		logic [15:0] stall_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] last;
		logic [19:0] period;
		logic [31:0] travel;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		count:  32'd0,
		last:   32'd0,
		period: PERIOD_RESET,
		travel: 32'd0
	};

	typedef struct packed {
		logic [NUM_W-1:0] dividend;
		logic [19:0]      divisor;
		logic [15:0]      limit;
	} div_req_t;

endpackage
`default_nettype wire

### src/odo_in_if.sv
`default_nettype none
interface odo_in_if;
	logic        valid;
	logic        ready;
	logic        channel;
	logic [31:0] now_us;
	logic        rising_edge;
	logic        clear;

	modport source(output valid, channel, now_us, rising_edge, clear, input ready);
	modport sink(input valid, channel, now_us, rising_edge, clear, output ready);
endinterface
`default_nettype wire

### src/odo_out_if.sv
`default_nettype none
interface odo_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pulse_total;
	logic [31:0] travelled;
	logic [19:0] pulse_period_us;
	logic [15:0] wheel_speed;
	logic        stalled;

	modport source(output valid, pulse_total, travelled, pulse_period_us, wheel_speed,
		stalled, input ready);
	modport sink(input valid, pulse_total, travelled, pulse_period_us, wheel_speed,
		stalled, output ready);
endinterface
`default_nettype wire

### src/wheel_encoder_odometry_unit.sv
`default_nettype none
// Period-based wheel odometry for up to NUM_CHANNELS encoder channels. Each
// transaction on item names a channel and gives a timestamp and edge/clear
// flags; one result transaction follows with the channel's pulse count,
// distance (Q16.16 cm), last accepted period, speed (Q8.8 cm/s, saturated at
// speed_limit) and a stall flag. Per-channel state sits in a registered-read
// memory and is read, updated and written back for each transaction. An item
// passes the update and check states, then the divider state when a speed is
// computed by the 17-step restoring divider with its start and finish steps,
// and the done state; a quotient beyond the divider range saturates at once,
// and a period outside the speed range skips the divider. A result held back
// by the sink adds its wait. One item is in work at a time and the next is taken
// the cycle after the result is registered; a finished result waits in the output
// register while the next item is accepted.
// Registers are written through cfg_we/cfg_index/cfg_data, by the user only while idle; not enforced.
module wheel_encoder_odometry_unit import odo_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	odo_in_if.sink               item,
	odo_out_if.source            result,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	cfg_t     cfg;
	entry_t   rd_entry;
	entry_t   new_entry;
	div_req_t div_req;
	logic     div_start;
	logic     div_done;
	logic [15:0] div_quo;

	logic [2:0]    state_q;
	logic          ch_ok_q;
	logic [AW-1:0] addr_q;
	logic [31:0]   now_q;
	logic          edge_q;
	logic          clr_q;

	logic [31:0]      cnt_q;
	logic [31:0]      dist_q;
	logic [19:0]      per_q;
	logic [31:0]      since_q;
	logic [26:0]      thr_q;
	logic [NUM_W-1:0] num_q;
	logic [15:0]      speed_q;
	logic             stalled_q;

	logic        out_valid_q;
	logic [31:0] out_cnt_q;
	logic [31:0] out_dist_q;
	logic [19:0] out_per_q;
	logic [15:0] out_speed_q;
	logic        out_stalled_q;

	logic          accept;
	logic          ch_ok;
	logic [31:0]   diff;
	logic          in_win;
	logic [31:0]   since;
	logic [26:0]   thr;
	logic [43:0]   num;
	logic          zero_speed;
	logic          out_free;

	odo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign accept = item.valid && item.ready;
	assign ch_ok  = 32'(item.channel) < 32'(NUM_CHANNELS);

	odo_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && ch_ok),
		.rd_addr (AW'(item.channel)),
		.wr_en   (state_q == ST_UPD && ch_ok_q),
		.wr_addr (addr_q),
		.wr_data (new_entry),
		.rd_data (rd_entry)
	);

	// read-modify-write of the channel entry
	always_comb begin
		diff      = now_q - rd_entry.last;
		in_win    = diff > {12'd0, cfg.period_min_us} && diff < {12'd0, cfg.period_max_us};
		new_entry = rd_entry;
		if (clr_q) begin
			new_entry.count  = '0;
			new_entry.travel = '0;
			new_entry.period = '0;
			new_entry.last   = now_q;
		end else if (edge_q) begin
			new_entry.count = rd_entry.count + 32'd1;
			if (rd_entry.last != '0 && in_win) begin
				new_entry.period = diff[19:0];
				new_entry.travel = rd_entry.travel + {8'd0, cfg.pulse_length};
			end
			new_entry.last = now_q;
		end
		since = now_q - new_entry.last;
	end

	// stalled when floor(since / 1000) > timeout, i.e. since > timeout * 1000 + 999
	assign thr = 27'(cfg.stall_timeout_ms) * US_PER_MS + US_PER_MS_LESS;
	assign num = {20'd0, cfg.pulse_length} * US_PER_S;

	assign zero_speed = per_q <= cfg.period_min_us || {4'd0, per_q} > cfg.speed_period_ceiling_us
		|| per_q == '0;

	assign div_start = state_q == ST_CHECK && ch_ok_q && !zero_speed;
	assign div_req   = '{dividend: num_q, divisor: per_q, limit: cfg.speed_limit};

	odo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= div_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_ok_q <= ch_ok;
			addr_q  <= AW'(item.channel);
			now_q   <= item.now_us;
			edge_q  <= item.rising_edge;
			clr_q   <= item.clear;
		end
		if (state_q == ST_UPD) begin
			thr_q <= thr;
			num_q <= num[43:8];
			if (ch_ok_q) begin
				cnt_q   <= new_entry.count;
				dist_q  <= new_entry.travel;
				per_q   <= new_entry.period;
				since_q <= since;
			end else begin
				cnt_q   <= '0;
				dist_q  <= '0;
				per_q   <= '0;
				since_q <= '0;
			end
		end
		if (state_q == ST_CHECK) begin
			stalled_q <= since_q > {5'd0, thr_q};
			speed_q   <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			speed_q <= div_quo;
		end
		if (state_q == ST_DONE && out_free) begin
			out_cnt_q     <= cnt_q;
			out_dist_q    <= dist_q;
			out_per_q     <= per_q;
			out_speed_q   <= speed_q;
			out_stalled_q <= stalled_q;
		end
	end

	assign item.ready = state_q == ST_IDLE;

	assign result.valid           = out_valid_q;
	assign result.pulse_total     = out_cnt_q;
	assign result.travelled       = out_dist_q;
	assign result.pulse_period_us = out_per_q;
	assign result.wheel_speed     = out_speed_q;
	assign result.stalled         = out_stalled_q;

endmodule
`default_nettype wire

### src/odo_cfg.sv
`default_nettype none
module odo_cfg import odo_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_length            <= DIST_PER_PULSE_RESET;
			cfg_q.period_min_us           <= PERIOD_MIN_RESET;
			cfg_q.period_max_us           <= PERIOD_MAX_RESET;
			cfg_q.speed_period_ceiling_us <= SPEED_CEILING_RESET;
			cfg_q.speed_limit             <= SPEED_LIMIT_RESET;
			cfg_q.stall_timeout_ms        <= STALL_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIST_PER_PULSE: cfg_q.pulse_length            <= cfg_data;
				CFG_PERIOD_MIN:     cfg_q.period_min_us           <= cfg_data[19:0];
				CFG_PERIOD_MAX:     cfg_q.period_max_us           <= cfg_data[19:0];
				CFG_SPEED_CEILING:  cfg_q.speed_period_ceiling_us <= cfg_data;
				CFG_SPEED_LIMIT:    cfg_q.speed_limit             <= cfg_data[15:0];
				CFG_STALL_TIMEOUT:  cfg_q.stall_timeout_ms        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/odo_mem.sv
`default_nettype none
module odo_mem import odo_pkg::*; #(
	parameter int DEPTH = NUM_CHANNELS_DEF,
	parameter int AW    = 1
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          rd_en,
	input  wire [AW-1:0] rd_addr,
	input  wire          wr_en,
	input  wire [AW-1:0] wr_addr,
	input  entry_t       wr_data,
	output entry_t       rd_data
);

	entry_t           mem_q [DEPTH];
	entry_t           raw_q;
	logic [DEPTH-1:0] valid_q;
	logic             raw_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as their reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			raw_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raw_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = raw_valid_q ? raw_q : ENTRY_RESET;

endmodule
`default_nettype wire

### src/odo_div.sv
`default_nettype none
module odo_div import odo_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  div_req_t    req,
	output logic        done,
	output logic [15:0] quotient
);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [15:0]       limit_q;
	logic [15:0]       result_q;
	logic              over;
	logic              take;

	assign over = {1'b0, req.dividend} >= {req.divisor, {QUO_W{1'b0}}};
	assign take = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= !over;
				done_q <= over;
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= req.dividend;
			dsh_q    <= {req.divisor, {(NUM_W-20){1'b0}}};
			quo_q    <= '0;
			step_q   <= STEP_W'(QUO_W - 1);
			limit_q  <= req.limit;
			result_q <= req.limit;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q  <= {quo_q[QUO_W-2:0], take};
			dsh_q  <= {1'b0, dsh_q[NUM_W-1:1]};
			step_q <= step_q - STEP_W'(1);
		end else if (fin_q) begin
			result_q <= (quo_q > {1'b0, limit_q}) ? limit_q : quo_q[15:0];
		end
	end

	assign done     = done_q;
	assign quotient = result_q;

endmodule
`default_nettype wire

### bench/tb_wheel_encoder_odometry_unit.sv
`timescale 1ns / 1ps
module tb_wheel_encoder_odometry_unit;
	import odo_pkg::*;

	localparam int CYCLE_LIMIT    = 2000000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASES         = 7;
	localparam int PHASE_EVENTS   = 240;
	localparam int PRINT_CAP      = 200;

	typedef struct packed {
		logic        channel;
		logic [31:0] now_us;
		logic        rising_edge;
		logic        clear;
		logic        drain;
	} enc_event_t;

	typedef struct packed {
		logic [31:0] pulse_total;
		logic [31:0] travelled;
		logic [19:0] pulse_period_us;
		logic [15:0] wheel_speed;
		logic        stalled;
	} odo_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic       drv_valid = 1'b0;
	enc_event_t drv_event = '0;
	logic       rx_ready = 1'b0;

	odo_in_if  in_if();
	odo_out_if out_if();

	assign in_if.valid       = drv_valid;
	assign in_if.channel     = drv_event.channel;
	assign in_if.now_us      = drv_event.now_us;
	assign in_if.rising_edge = drv_event.rising_edge;
	assign in_if.clear       = drv_event.clear;
	assign out_if.ready      = rx_ready;

	wheel_encoder_odometry_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_if),
		.result(out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// odometer state mirrored per channel
	cfg_t        model_cfg;
	logic [31:0] pulses     [NUM_CHANNELS_DEF];
	logic [31:0] last_edge  [NUM_CHANNELS_DEF];
	logic [19:0] period     [NUM_CHANNELS_DEF];
	logic [31:0] distance   [NUM_CHANNELS_DEF];
	logic [31:0] gen_clock  [NUM_CHANNELS_DEF];

	enc_event_t   encoder_events[$];
	odo_reading_t readings_due[$];
	odo_reading_t due_reading;

	int items_sent = 0;
	int results_seen = 0;
	int sent_now;
	int tx_gap = 0;
	int rx_stall = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [15:0] wheel_speed_of(logic [19:0] per);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		if (per == 0 || per <= model_cfg.period_min_us || per > model_cfg.speed_period_ceiling_us)
			return 16'd0;
		num = 64'(model_cfg.pulse_length);
		num = num * 64'd1000000;
		den = 64'(per);
		den = den << 8;
		quo = num / den;
		if (quo > 64'(model_cfg.speed_limit))
			quo = 64'(model_cfg.speed_limit);
		return quo[15:0];
	endfunction

	function automatic odo_reading_t advance_odometer(enc_event_t ev);
		odo_reading_t r;
		logic [31:0] gap_us;
		logic [31:0] since_ms;
		int ch;
		ch = ev.channel;
		if (ev.clear) begin
			pulses[ch] = 32'd0;
			distance[ch] = 32'd0;
			period[ch] = 20'd0;
			last_edge[ch] = ev.now_us;
		end else if (ev.rising_edge) begin
			pulses[ch] = pulses[ch] + 32'd1;
			if (last_edge[ch] != 32'd0) begin
				gap_us = ev.now_us - last_edge[ch];
				if (gap_us > model_cfg.period_min_us && gap_us < model_cfg.period_max_us) begin
					period[ch] = gap_us[19:0];
					distance[ch] = distance[ch] + {8'd0, model_cfg.pulse_length};
				end
			end
			last_edge[ch] = ev.now_us;
		end
		gap_us = ev.now_us - last_edge[ch];
		since_ms = gap_us / 32'd1000;
		r.pulse_total = pulses[ch];
		r.travelled = distance[ch];
		r.pulse_period_us = period[ch];
		r.wheel_speed = wheel_speed_of(period[ch]);
		r.stalled = since_ms > model_cfg.stall_timeout_ms;
		return r;
	endfunction

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			items_sent <= 0;
			tx_gap = 0;
		end else begin
			sent_now = items_sent;
			if (drv_valid && in_if.ready) begin
				readings_due.push_back(advance_odometer(drv_event));
				encoder_events.delete(0);
				items_sent <= items_sent + 1;
				sent_now = items_sent + 1;
				tx_gap = pick_gap(tx_idle);
			end
			if (!drv_valid || in_if.ready) begin
				if (tx_gap > 0) begin
					drv_valid <= 1'b0;
					tx_gap--;
				end else if (encoder_events.size() != 0 &&
						(!encoder_events[0].drain || sent_now == results_seen)) begin
					drv_event <= encoder_events[0];
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
			results_seen <= 0;
			rx_stall = 0;
		end else begin
			if (out_if.valid && rx_ready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("result transaction with nothing pending", 32'd0, 32'd0);
				end else begin
					due_reading = readings_due.pop_front();
					check_field("pulse_total", out_if.pulse_total, due_reading.pulse_total);
					check_field("travelled", out_if.travelled, due_reading.travelled);
					check_field("pulse_period_us", out_if.pulse_period_us,
						due_reading.pulse_period_us);
					check_field("wheel_speed", out_if.wheel_speed, due_reading.wheel_speed);
					check_field("stalled", out_if.stalled, due_reading.stalled);
					results_seen <= results_seen + 1;
				end
			end
			if (rx_stall > 0) begin
				rx_ready <= 1'b0;
				rx_stall--;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				rx_ready <= 1'b0;
				rx_stall = pick_gap(1'b1);
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIST_PER_PULSE: model_cfg.pulse_length = value[23:0];
			CFG_PERIOD_MIN:     model_cfg.period_min_us = value[19:0];
			CFG_PERIOD_MAX:     model_cfg.period_max_us = value[19:0];
			CFG_SPEED_CEILING:  model_cfg.speed_period_ceiling_us = value[23:0];
			CFG_SPEED_LIMIT:    model_cfg.speed_limit = value[15:0];
			CFG_STALL_TIMEOUT:  model_cfg.stall_timeout_ms = value[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [23:0] dpp, input logic [23:0] pmin,
			input logic [23:0] pmax, input logic [23:0] ceiling, input logic [23:0] lim,
			input logic [23:0] timeout);
		set_register(CFG_DIST_PER_PULSE, dpp);
		set_register(CFG_PERIOD_MIN, pmin);
		set_register(CFG_PERIOD_MAX, pmax);
		set_register(CFG_SPEED_CEILING, ceiling);
		set_register(CFG_SPEED_LIMIT, lim);
		set_register(CFG_STALL_TIMEOUT, timeout);
		for (int i = CFG_STALL_TIMEOUT + 1; i < 2 ** CFG_IDX_W; i++)
			set_register(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
	endtask

	task automatic push_event(input logic chan, input logic [31:0] stamp, input logic rise,
			input logic clr, input logic hold);
		enc_event_t ev;
		ev.channel = chan;
		ev.now_us = stamp;
		ev.rising_edge = rise;
		ev.clear = clr;
		ev.drain = hold;
		encoder_events.push_back(ev);
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (encoder_events.size() != 0 || drv_valid || items_sent != results_seen);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] edge_delta();
		logic [31:0] lo;
		logic [31:0] hi;
		lo = 32'(model_cfg.period_min_us);
		hi = 32'(model_cfg.period_max_us);
		case ($urandom_range(0, 9))
			0: return lo + $urandom_range(0, 2) - 1;
			1: return hi + $urandom_range(0, 2) - 1;
			2: return $urandom_range(0, 3000);
			3: return $urandom;
			default: return (hi > lo + 1) ? $urandom_range(lo + 1, hi - 1)
				: $urandom_range(0, 2000000);
		endcase
	endfunction

	function automatic logic [31:0] quiet_delta();
		logic [31:0] limit_us;
		limit_us = 32'(model_cfg.stall_timeout_ms);
		limit_us = limit_us * 1000;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 5000);
			default: return limit_us + $urandom_range(0, 2000);
		endcase
	endfunction

	task automatic queue_encoder_traffic(input int count);
		enc_event_t ev;
		logic [31:0] bits;
		int ch;
		int pick;
		for (int n = 0; n < count; n++) begin
			ch = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			bits = $urandom;
			ev = '0;
			ev.channel = bits[0];
			ev.drain = ($urandom_range(0, 99) == 0);
			if (pick < 4) begin
				ev.now_us = $urandom;
				ev.rising_edge = bits[1];
				ev.clear = bits[2];
			end else begin
				ev.channel = ch[0];
				if (pick < 7) begin
					ev.clear = 1'b1;
					ev.rising_edge = bits[1];
					ev.now_us = gen_clock[ch] + $urandom_range(0, 5000);
					gen_clock[ch] = ev.now_us;
				end else if (pick < 17) begin
					ev.now_us = gen_clock[ch] + quiet_delta();
				end else begin
					ev.rising_edge = 1'b1;
					ev.now_us = gen_clock[ch] + edge_delta();
					gen_clock[ch] = ev.now_us;
				end
			end
			encoder_events.push_back(ev);
		end
	endtask

	initial begin
		logic [31:0] pmin;
		logic [31:0] pmax;
		model_cfg.pulse_length = DIST_PER_PULSE_RESET;
		model_cfg.period_min_us = PERIOD_MIN_RESET;
		model_cfg.period_max_us = PERIOD_MAX_RESET;
		model_cfg.speed_period_ceiling_us = SPEED_CEILING_RESET;
		model_cfg.speed_limit = SPEED_LIMIT_RESET;
		model_cfg.stall_timeout_ms = STALL_TIMEOUT_RESET;
		for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
			pulses[i] = 32'd0;
			last_edge[i] = 32'd0;
			period[i] = PERIOD_RESET;
			distance[i] = 32'd0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window edges, zero timestamps, clear priority, stall boundary
		push_event(1'b0, 32'd5000, 1'b0, 1'b0, 1'b0);
		push_event(1'b0, 32'd0, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd3000, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd53000, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd54000, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd55001, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd1055000, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd2055000, 1'b1, 1'b0, 1'b0);
		push_event(1'b0, 32'd2255999, 1'b0, 1'b0, 1'b0);
		push_event(1'b0, 32'd2256000, 1'b0, 1'b0, 1'b0);
		push_event(1'b1, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1);
		push_event(1'b1, 32'h0001_0000, 1'b1, 1'b0, 1'b0);
		push_event(1'b1, 32'h0001_0000, 1'b0, 1'b1, 1'b0);
		push_event(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
		push_event(1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
		push_event(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
		push_event(1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
		push_event(1'b1, 32'd60000, 1'b1, 1'b0, 1'b0);
		push_event(1'b1, 32'd61500, 1'b1, 1'b0, 1'b1);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_settings(DIST_PER_PULSE_RESET, 24'(PERIOD_MIN_RESET),
					24'(PERIOD_MAX_RESET), SPEED_CEILING_RESET, 24'(SPEED_LIMIT_RESET),
					24'(STALL_TIMEOUT_RESET));
				1: apply_settings('0, '0, '0, '0, '0, '0);
				2: apply_settings('1, '1, '1, '1, '1, '1);
				3: apply_settings('1, '0, 24'hFFFFF, '1, 24'hFFFF, '0);
				default: begin
					pmin = $urandom_range(0, 4000);
					pmax = $urandom_range(pmin + 2, 20'hFFFFF);
					apply_settings(24'($urandom), 24'(pmin), 24'(pmax),
						24'($urandom_range(pmin, pmax + 200000)),
						24'($urandom), 24'($urandom_range(0, 2000)));
				end
			endcase
			tx_idle = (phase != 0 && phase != 5);
			rx_idle = (phase != 0 && phase != 4);
			gen_clock[0] = $urandom;
			gen_clock[1] = $urandom;
			queue_encoder_traffic(PHASE_EVENTS);
			settle();
		end

		if (readings_due.size() != 0)
			report_mismatch("readings never returned", readings_due.size(), 32'd0);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
